@@ rtl/frb_pkg.sv @@
`default_nettype none
package frb_pkg;

  localparam int MAX_FRAGMENTS_DEF = 8;
  localparam int PAYLOAD_BYTES_DEF = 56;
  localparam int IDENT_BYTES_DEF   = 4;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_FRAG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam int IDX_W   = 4;
  localparam int IDENT_W = 32;
  localparam int OFFS_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 9;
  localparam int TLEN_W  = 9;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  // Per-transaction result held between the session and output stages
  typedef struct packed {
    logic              accepted;
    logic              complete;
    logic              in_range;
    logic              present;
    logic [TLEN_W-1:0] total_length;
  } frb_res_t;

endpackage
`default_nettype wire

@@ rtl/frb_store.sv @@
`default_nettype none
module frb_store #(
  parameter int DEPTH = 448,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] store_mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next transaction loads the stage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/frb_session.sv @@
`default_nettype none
module frb_session #(
  parameter int MAX_FRAGMENTS = frb_pkg::MAX_FRAGMENTS_DEF,
  parameter int PAYLOAD_BYTES = frb_pkg::PAYLOAD_BYTES_DEF,
  parameter int IDENT_BYTES   = frb_pkg::IDENT_BYTES_DEF,
  parameter int SAW           = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        acc,
  input  wire logic [frb_pkg::KIND_W-1:0]  kind,
  input  wire logic [frb_pkg::IDX_W-1:0]   frag_index,
  input  wire logic                        last_fragment,
  input  wire logic [frb_pkg::IDENT_W-1:0] packet_ident,
  input  wire logic [frb_pkg::OFFS_W-1:0]  byte_offset,
  input  wire logic [frb_pkg::ADDR_W-1:0]  read_address,
  input  wire logic [frb_pkg::ADDR_W-1:0]  read_limit,
  output logic                             wr_en,
  output logic      [SAW-1:0]              wr_addr,
  output logic                             rd_en,
  output logic      [SAW-1:0]              rd_addr,
  output frb_pkg::frb_res_t                res
);

  localparam int STORE_DEPTH = MAX_FRAGMENTS * PAYLOAD_BYTES;
  localparam int TOTW        = $clog2(MAX_FRAGMENTS + 1);
  localparam logic [frb_pkg::IDENT_W-1:0] IDENT_MASK =
    (IDENT_BYTES >= 4) ? {frb_pkg::IDENT_W{1'b1}} :
    frb_pkg::IDENT_W'((64'd1 << (8 * IDENT_BYTES)) - 64'd1);

  logic                        active_r, active_nxt;
  logic [frb_pkg::IDENT_W-1:0] ident_r, ident_nxt;
  logic [MAX_FRAGMENTS-1:0]    bits_r, bits_nxt;
  logic [TOTW-1:0]             total_r, total_nxt;

  logic [frb_pkg::IDENT_W-1:0] ident_m;
  logic                        frag_ok;
  logic                        new_sess;
  logic                        last_byte;
  logic                        comp;
  logic                        present;
  logic                        in_range;
  logic [31:0]                 tl_cur;
  logic [31:0]                 tl_nxt;
  logic [31:0]                 addr_ext;

  assign ident_m  = packet_ident & IDENT_MASK;
  assign addr_ext = 32'(read_address);
  assign frag_ok  = (32'(frag_index) < MAX_FRAGMENTS) && (32'(byte_offset) < PAYLOAD_BYTES);
  assign new_sess = (byte_offset == '0) && (!active_r || (ident_r != ident_m));
  assign last_byte = (32'(byte_offset) == PAYLOAD_BYTES - 1);

  always_comb begin
    active_nxt = active_r;
    ident_nxt  = ident_r;
    bits_nxt   = bits_r;
    total_nxt  = total_r;
    comp       = 1'b0;
    case (kind)
      frb_pkg::KIND_FRAG: begin
        if (frag_ok) begin
          if (new_sess) begin
            active_nxt = 1'b1;
            ident_nxt  = ident_m;
            bits_nxt   = '0;
            total_nxt  = '0;
          end
          if (last_byte) begin
            for (int i = 0; i < MAX_FRAGMENTS; i++) begin
              if (32'(frag_index) == i) begin
                bits_nxt[i] = 1'b1;
              end
            end
            if (last_fragment) begin
              total_nxt = TOTW'(32'(frag_index) + 32'd1);
            end
            comp = (total_nxt != '0);
            for (int i = 0; i < MAX_FRAGMENTS; i++) begin
              if ((i < 32'(total_nxt)) && !bits_nxt[i]) begin
                comp = 1'b0;
              end
            end
          end
        end
      end
      frb_pkg::KIND_CLEAR: begin
        active_nxt = 1'b0;
        ident_nxt  = '0;
        bits_nxt   = '0;
        total_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // Read window check against the current session
  always_comb begin
    tl_cur   = 32'(total_r) * PAYLOAD_BYTES;
    in_range = active_r && (total_r != '0) && (addr_ext < tl_cur) &&
               (addr_ext < 32'(read_limit)) && (addr_ext < STORE_DEPTH);
    present  = 1'b0;
    for (int i = 0; i < MAX_FRAGMENTS; i++) begin
      if ((addr_ext >= i * PAYLOAD_BYTES) && (addr_ext < (i + 1) * PAYLOAD_BYTES) &&
          bits_r[i]) begin
        present = 1'b1;
      end
    end
  end

  assign tl_nxt = 32'(total_nxt) * PAYLOAD_BYTES;

  always_comb begin
    res.accepted     = (kind == frb_pkg::KIND_FRAG) && frag_ok;
    res.complete     = (kind == frb_pkg::KIND_FRAG) && comp;
    res.in_range     = (kind == frb_pkg::KIND_READ) && in_range;
    res.present      = present;
    res.total_length = tl_nxt[frb_pkg::TLEN_W-1:0];
  end

  assign wr_en   = acc && (kind == frb_pkg::KIND_FRAG) && frag_ok;
  assign wr_addr = SAW'(32'(frag_index) * PAYLOAD_BYTES + 32'(byte_offset));
  assign rd_en   = acc;
  assign rd_addr = SAW'(read_address);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ident_r  <= '0;
      bits_r   <= '0;
      total_r  <= '0;
    end else if (acc) begin
      active_r <= active_nxt;
      ident_r  <= ident_nxt;
      bits_r   <= bits_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fragment_reassembly_bitmap.sv @@
`default_nettype none
// Channel  Dir  Ports                      Contents
// in_      in   tvalid tready tdata tuser  one fragment byte, read or session reset
//                             tlast        last_fragment
// out_     out  tvalid tready tdata        one result per input transaction
//
// One transaction per cycle in, one result per cycle out while out_tready is high;
// each passes the session update and payload memory read, then the output register.
// The payload store is a single-port-write, single-port-read memory with a
// registered read; the session registers update on acceptance.
// rst_n (synchronous) clears the session and holds in_tready low; payload
// memory is not cleared.
// Output stalls back up through a two-entry pipeline, so one more transaction
// is taken while a result waits.
module fragment_reassembly_bitmap #(
  parameter int MAX_FRAGMENTS = frb_pkg::MAX_FRAGMENTS_DEF,
  parameter int PAYLOAD_BYTES = frb_pkg::PAYLOAD_BYTES_DEF,
  parameter int IDENT_BYTES   = frb_pkg::IDENT_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [3:0] frag_index, [35:4] packet_ident, [41:36] byte_offset,
  // [49:42] payload_byte, [58:50] read_address, [67:59] read_limit
  input  wire logic [frb_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] kind
  input  wire logic [frb_pkg::KIND_W-1:0]      in_tuser,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] accepted, [1] complete, [9:2] read_value, [10] read_in_range,
  // [19:11] total_length
  output logic      [frb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int STORE_DEPTH = MAX_FRAGMENTS * PAYLOAD_BYTES;
  localparam int SAW         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                    in_acc;
  logic                    s1_adv;
  logic                    s1_v_r;
  frb_pkg::frb_res_t       s1_res_r;
  frb_pkg::frb_res_t       res;
  logic                    out_v_r;
  logic [frb_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                    wr_en;
  logic [SAW-1:0]          wr_addr;
  logic                    rd_en;
  logic [SAW-1:0]          rd_addr;
  logic [7:0]              rd_data;
  logic [7:0]              rval;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = rst_n && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  frb_session #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .IDENT_BYTES   (IDENT_BYTES),
    .SAW           (SAW)
  ) u_session (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .kind          (in_tuser),
    .frag_index    (in_tdata[3:0]),
    .last_fragment (in_tlast),
    .packet_ident  (in_tdata[35:4]),
    .byte_offset   (in_tdata[41:36]),
    .read_address  (in_tdata[58:50]),
    .read_limit    (in_tdata[67:59]),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .res           (res)
  );

  frb_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (SAW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[49:42]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Zero the byte when out of window or fragment missing
  assign rval = (s1_res_r.in_range && s1_res_r.present) ? rd_data : 8'd0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_data_r <= {4'd0, s1_res_r.total_length, s1_res_r.in_range, rval,
                     s1_res_r.complete, s1_res_r.accepted};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
